/* hdl/sha_pkg.sv */
// package: sha-256 constants, round functions and sequencer states
package sha_pkg;

    localparam int WordBits  = 32;
    localparam int BlockBits = 512;

    localparam logic       KIND_BYTE   = 1'b0;
    localparam logic       KIND_FINISH = 1'b1;
    localparam logic [7:0] PAD_FIRST   = 8'h80;
    localparam logic [5:0] LEN_START   = 6'd56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (WordBits - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

/* hdl/sha256_byte_stream_hash.sv */
// top level: sha-256 over a byte stream with one shared round unit
//
// input channel (in_valid / in_ready): one word per handshake, kind selects a
// message byte (data_byte) or finish. the 64th byte of a block starts the
// compression, which runs 64 rounds on the single round unit and then folds
// the working variables into the chaining value in an update step.
// in_ready is low while a block compresses, while padding runs and while the
// digest is being sent.
// finish: the pad bytes (0x80, zero fill, 64-bit bit length) go into the block
// one per cycle through the same byte path, using one or two compressions, two
// when fewer than 9 bytes are free.
// output channel (out_valid / out_ready): eight digest words, word_index 0..7,
// last_word on index 7. words come straight from the hash registers and hold
// while the receiver stalls; one word per cycle when out_ready stays high.
// after the last word the hash restarts for a new message.
// reset (rst_n, async, active low): initial hash values, empty block, zero
// length, ready at once.
module sha256_byte_stream_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha_pkg::*;

    // control state
    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] msg_reg, msg_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic        pad_mode_reg, pad_mode_next;   // finish in progress
    logic        first_pad_reg, first_pad_next; // next pad byte is 0x80
    logic        len_blk_reg, len_blk_next;     // current block carries the length
    logic [31:0] hash_reg [8];
    logic [31:0] hash_next [8];

    // datapath: 16-word block / schedule shift line and working variables
    logic [BlockBits-1:0] blk_reg, blk_next;
    logic [31:0]          vars_reg [8];
    logic [31:0]          vars_next [8];

    logic        shift_en;
    logic [7:0]  shift_byte;
    logic [63:0] bit_len;
    logic [2:0]  len_sel;
    logic [7:0]  len_byte;

    // schedule taps: w[r], w[r+1], w[r+9], w[r+14]
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2;

    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign w_new = small_s1(w14) + w9 + small_s0(w1) + w0;

    assign t1 = vars_reg[7] + big_s1(vars_reg[4])
              + choose(vars_reg[4], vars_reg[5], vars_reg[6])
              + ROUND_K[round_reg] + w0;
    assign t2 = big_s0(vars_reg[0]) + majority(vars_reg[0], vars_reg[1], vars_reg[2]);

    // length bytes, most significant first at block offsets 56..63
    assign bit_len  = {msg_reg, 3'b000};
    assign len_sel  = ~fill_reg[2:0];
    assign len_byte = bit_len[{len_sel, 3'b000} +: 8];

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = hash_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        msg_next       = msg_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        pad_mode_next  = pad_mode_reg;
        first_pad_next = first_pad_reg;
        len_blk_next   = len_blk_reg;
        hash_next      = hash_reg;
        blk_next       = blk_reg;
        vars_next      = vars_reg;
        shift_en       = 1'b0;
        shift_byte     = data_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_FINISH)
                    begin
                        state_next     = ST_PAD;
                        pad_mode_next  = 1'b1;
                        first_pad_next = 1'b1;
                        len_blk_next   = (fill_reg < LEN_START);
                    end
                    else
                    begin
                        shift_en   = 1'b1;
                        shift_byte = data_byte;
                        msg_next   = msg_reg + 61'd1;
                    end
                end
            end
            ST_PAD:
            begin
                shift_en       = 1'b1;
                first_pad_next = 1'b0;
                if (first_pad_reg)
                    shift_byte = PAD_FIRST;
                else if (len_blk_reg && (fill_reg >= LEN_START))
                    shift_byte = len_byte;
                else
                    shift_byte = 8'h00;
            end
            ST_ROUND:
            begin
                blk_next    = {blk_reg[479:0], w_new};
                vars_next[7] = vars_reg[6];
                vars_next[6] = vars_reg[5];
                vars_next[5] = vars_reg[4];
                vars_next[4] = vars_reg[3] + t1;
                vars_next[3] = vars_reg[2];
                vars_next[2] = vars_reg[1];
                vars_next[1] = vars_reg[0];
                vars_next[0] = t1 + t2;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                for (int j = 0; j < 8; j++)
                    hash_next[j] = hash_reg[j] + vars_reg[j];
                if (!pad_mode_reg)
                    state_next = ST_IDLE;
                else if (len_blk_reg)
                begin
                    state_next   = ST_OUT;
                    out_idx_next = 3'd0;
                end
                else
                begin
                    // second pad block: zero fill then length
                    state_next   = ST_PAD;
                    len_blk_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'd7)
                    begin
                        state_next    = ST_IDLE;
                        hash_next     = H_INIT;
                        fill_next     = 6'd0;
                        msg_next      = 61'd0;
                        pad_mode_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // shared byte path for message and pad bytes
        if (shift_en)
        begin
            blk_next  = {blk_reg[503:0], shift_byte};
            fill_next = fill_reg + 6'd1;
            if (fill_reg == 6'd63)
            begin
                vars_next  = hash_reg;
                round_next = 6'd0;
                state_next = ST_ROUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            msg_reg       <= 61'd0;
            round_reg     <= 6'd0;
            out_idx_reg   <= 3'd0;
            pad_mode_reg  <= 1'b0;
            first_pad_reg <= 1'b0;
            len_blk_reg   <= 1'b0;
            hash_reg      <= H_INIT;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            msg_reg       <= msg_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            pad_mode_reg  <= pad_mode_next;
            first_pad_reg <= first_pad_next;
            len_blk_reg   <= len_blk_next;
            hash_reg      <= hash_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        vars_reg <= vars_next;
    end

endmodule
